// ----- rtl/nlqt_pkg.sv -----
`timescale 1ns / 1ps
package nlqt_pkg;

  localparam int Slots = 4;
  localparam int SlotW = 2;

  localparam logic [1:0] CMD_HELLO  = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  localparam logic [1:0] ST_UPDATED  = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_DONE     = 2'd3;

  localparam logic [7:0] MAX_AGE_RESET = 8'd15;

  // Divider: 24-bit dividend, one quotient bit per cycle.
  localparam int DivBits = 24;
  localparam logic [4:0] DIV_LAST = 5'd23;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input word and classify it
    logic div_start; // load the divider operands
    logic div_step;  // one quotient bit
    logic div_swap;  // first average done, start the second
    logic commit;    // write the table and build the result
  } nlqt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;  // a hello that hit a live entry
  } nlqt_stat_t;

endpackage

// ----- rtl/nlqt_ctrl.sv -----
`timescale 1ns / 1ps
module nlqt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  nlqt_pkg::nlqt_stat_t stat,
  output nlqt_pkg::nlqt_cmd_t  cmd
);
  import nlqt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_DIVA = 3'd2;
  localparam logic [2:0] S_DIVB = 3'd3;
  localparam logic [2:0] S_COMM = 3'd4;

  logic [2:0] state, state_next;
  logic [4:0] cnt, cnt_next;
  logic       ovalid, ovalid_next;
  logic       accept;

  // A new word is taken only in the idle state, once the output register is free or being drained.
  assign in_stall  = (state != S_IDLE) || (ovalid && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = ovalid;

  // Sequencer for one word.
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    ovalid_next = ovalid && out_stall;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.need_div) begin
          cmd.div_start = 1'b1;
          cnt_next = '0;
          state_next = S_DIVA;
        end else begin
          state_next = S_COMM;
        end
      end
      S_DIVA: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 5'd1;
        if (cnt == DIV_LAST) begin
          cnt_next = '0;
          state_next = S_DIVB;
        end
      end
      S_DIVB: begin
        if (cnt == 5'd0) begin
          cmd.div_swap = 1'b1;
        end else begin
          cmd.div_step = 1'b1;
        end
        cnt_next = cnt + 5'd1;
        if (cnt == DIV_LAST + 5'd1) begin
          state_next = S_COMM;
        end
      end
      S_COMM: begin
        cmd.commit = 1'b1;
        ovalid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      ovalid <= ovalid_next;
    end
  end
endmodule

// ----- rtl/nlqt_dp.sv -----
`timescale 1ns / 1ps
module nlqt_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  nlqt_pkg::nlqt_cmd_t  cmd,
  output nlqt_pkg::nlqt_stat_t stat,
  input  logic                 max_age_we,
  input  logic [7:0]           max_age_wdata,
  input  logic [1:0]           command,
  input  logic [15:0]          neighbor_addr,
  input  logic [15:0]          rssi_sample,
  input  logic [15:0]          lqi_sample,
  input  logic [7:0]           now_seconds,
  input  logic [1:0]           read_slot,
  output logic [1:0]           status,
  output logic [1:0]           slot,
  output logic                 entry_valid,
  output logic [15:0]          entry_addr,
  output logic [15:0]          entry_rssi,
  output logic [15:0]          entry_lqi,
  output logic [7:0]           entry_count,
  output logic [7:0]           entry_last_seen,
  output logic [3:0]           removed_mask
);
  import nlqt_pkg::*;

  logic [7:0]  max_age;
  logic [Slots-1:0] vld;
  logic [15:0] taddr [Slots];
  logic [15:0] trssi [Slots];
  logic [15:0] tlqi  [Slots];
  logic [7:0]  tcnt  [Slots];
  logic [7:0]  tseen [Slots];

  // Captured word.
  logic [1:0]  c_cmd;
  logic [15:0] c_addr, c_rssi, c_lqi;
  logic [7:0]  c_now;
  logic [1:0]  c_rslot;

  // Classification registered in the decode cycle.
  logic             hit_f, free_f;
  logic [SlotW-1:0] hit_i, free_i;
  logic [Slots-1:0] old_m;
  logic             hit_c, free_c;
  logic [SlotW-1:0] hit_ic, free_ic;
  logic [Slots-1:0] old_c;

  // Divider.
  logic [DivBits-1:0] dvd, quo, q_rssi;
  logic [8:0]         dvs;
  logic [9:0]         rem, trial;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_age <= MAX_AGE_RESET;
    end else if (max_age_we) begin
      max_age <= max_age_wdata;
    end
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_cmd <= command;
      c_addr <= neighbor_addr;
      c_rssi <= rssi_sample;
      c_lqi <= lqi_sample;
      c_now <= now_seconds;
      c_rslot <= read_slot;
    end
  end

  // Match, free-slot and age search over the table.
  always_comb begin
    hit_c = 1'b0;
    free_c = 1'b0;
    hit_ic = '0;
    free_ic = '0;
    for (int i = 0; i < Slots; i++) begin
      old_c[i] = vld[i] && ((c_now - tseen[i]) > max_age);
      if (vld[i] && taddr[i] == c_addr && !hit_c) begin
        hit_c = 1'b1;
        hit_ic = SlotW'(i);
      end
      if (!vld[i] && !free_c) begin
        free_c = 1'b1;
        free_ic = SlotW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_f <= hit_c;
    free_f <= free_c;
    hit_i <= hit_ic;
    free_i <= free_ic;
    old_m <= old_c;
  end

  assign stat.need_div = (c_cmd == CMD_HELLO) && hit_c;

  // Restoring divider, one quotient bit per step.
  assign trial = {rem[8:0], dvd[DivBits-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd <= DivBits'(trssi[hit_ic]) * DivBits'(tcnt[hit_ic]) + DivBits'(c_rssi);
      dvs <= {1'b0, tcnt[hit_ic]} + 9'd1;
      rem <= '0;
      quo <= '0;
    end else if (cmd.div_swap) begin
      q_rssi <= quo;
      dvd <= DivBits'(tlqi[hit_i]) * DivBits'(tcnt[hit_i]) + DivBits'(c_lqi);
      rem <= '0;
      quo <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[DivBits-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem <= trial - {1'b0, dvs};
        quo <= {quo[DivBits-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[DivBits-2:0], 1'b0};
      end
    end
  end

  // Table update and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      for (int i = 0; i < Slots; i++) begin
        taddr[i] <= '0;
        trssi[i] <= '0;
        tlqi[i] <= '0;
        tcnt[i] <= '0;
        tseen[i] <= '0;
      end
    end else if (cmd.commit) begin
      status <= ST_DONE;
      slot <= '0;
      entry_valid <= 1'b0;
      entry_addr <= '0;
      entry_rssi <= '0;
      entry_lqi <= '0;
      entry_count <= '0;
      entry_last_seen <= '0;
      removed_mask <= '0;
      case (c_cmd)
        CMD_HELLO: begin
          if (hit_f) begin
            trssi[hit_i] <= q_rssi[15:0];
            tlqi[hit_i] <= quo[15:0];
            if (tcnt[hit_i] != 8'hFF) begin
              tcnt[hit_i] <= tcnt[hit_i] + 8'd1;
            end
            tseen[hit_i] <= c_now;
            status <= ST_UPDATED;
            slot <= 2'(hit_i);
          end else if (free_f) begin
            vld[free_i] <= 1'b1;
            taddr[free_i] <= c_addr;
            trssi[free_i] <= c_rssi;
            tlqi[free_i] <= c_lqi;
            tcnt[free_i] <= 8'd1;
            tseen[free_i] <= c_now;
            status <= ST_INSERTED;
            slot <= 2'(free_i);
          end else begin
            status <= ST_FULL;
          end
        end
        CMD_TICK: begin
          vld <= vld & ~old_m;
          removed_mask <= 4'(old_m);
        end
        CMD_REPORT: begin
          for (int i = 0; i < Slots; i++) begin
            if (vld[i]) begin
              tcnt[i] <= 8'd1;
            end
          end
        end
        default: begin
          slot <= c_rslot;
          if (vld[c_rslot]) begin
            entry_valid <= 1'b1;
            entry_addr <= taddr[c_rslot];
            entry_rssi <= trssi[c_rslot];
            entry_lqi <= tlqi[c_rslot];
            entry_count <= tcnt[c_rslot];
            entry_last_seen <= tseen[c_rslot];
          end
        end
      endcase
    end
  end
endmodule

// ----- rtl/neighbor_link_quality_table_unit.sv -----
`timescale 1ns / 1ps
// Every word passes through the decode and commit states; a hello that updates a live
// entry also runs two 24-step divisions between them.
// One word at a time: the next is taken, at the earliest, in the cycle its result is taken.
// The shared restoring divider sets the update time.
// Reset (rst, synchronous) clears the table and sets max_age to 15.
module neighbor_link_quality_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [15:0] neighbor_addr,
  input  logic [15:0] rssi_sample,
  input  logic [15:0] lqi_sample,
  input  logic [7:0]  now_seconds,
  input  logic [1:0]  read_slot,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [1:0]  slot,
  output logic        entry_valid,
  output logic [15:0] entry_addr,
  output logic [15:0] entry_rssi,
  output logic [15:0] entry_lqi,
  output logic [7:0]  entry_count,
  output logic [7:0]  entry_last_seen,
  output logic [3:0]  removed_mask
);
  import nlqt_pkg::*;

  nlqt_cmd_t  cmd;
  nlqt_stat_t stat;

  // Sequencer.
  nlqt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
  );

  // Table, divider and result register.
  nlqt_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .max_age_we(cfg_we), .max_age_wdata(cfg_wdata),
    .command(command), .neighbor_addr(neighbor_addr),
    .rssi_sample(rssi_sample), .lqi_sample(lqi_sample),
    .now_seconds(now_seconds), .read_slot(read_slot),
    .status(status), .slot(slot), .entry_valid(entry_valid),
    .entry_addr(entry_addr), .entry_rssi(entry_rssi), .entry_lqi(entry_lqi),
    .entry_count(entry_count), .entry_last_seen(entry_last_seen),
    .removed_mask(removed_mask)
  );
endmodule
